>>> src/mean_filter_3x3_edge_normalized_defines.svh
// Assertion macros shared by the 3x3 mean filter RTL.
`ifndef MEAN_FILTER_3X3_EDGE_NORMALIZED_DEFINES_SVH
`define MEAN_FILTER_3X3_EDGE_NORMALIZED_DEFINES_SVH

// Condition holds in the same cycle.
`define MF3_ASSERT_HOLDS(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Condition holds in the following cycle.
`define MF3_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

// Condition holds after the delay given by argument n.
`define MF3_ASSERT_DELAY(label, pre, n, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> ##n (post)) \
    else $error(msg);

`endif

>>> src/mf3_pkg.sv
// Shared types and constants of the 3x3 mean filter.
package mf3_pkg;

  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int ROWS_W     = 13;
  localparam int COLS_W     = 11;
  localparam int OUT_MEAN_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 1'd1;

  // First window row that enters the sum.
  localparam logic [1:0] TLO_ALL    = 2'd0;
  localparam logic [1:0] TLO_LOWER2 = 2'd1;
  localparam logic [1:0] TLO_BOTTOM = 2'd2;

  typedef struct packed {
    logic       left_en;
    logic       right_en;
    logic [1:0] tlo;
  } mf3_shape_t;

endpackage

>>> src/mean_filter_3x3_edge_normalized.sv
// 3x3 edge-normalized box mean over a raster pixel stream: control and line buffers.
//
// Pixels of a frame_rows x frame_cols frame enter in raster order; each pixel's
// 3x3 mean, averaged over the neighbours that lie inside the frame, leaves as a
// signed value with 8 fraction bits, rounded to nearest with ties away from zero,
// together with its row, column, a mark on the last result of each input
// transaction and a mark on the frame's final result. A result leaves once its
// lower-right neighbour has arrived; last-column and last-row results follow the
// pixel that completes them, so one pixel causes zero to four results. An input
// transaction passes through the line buffer read, its write back, a four-slot
// result sequencer and the window shift; each result adds the four-stage mean
// unit and the output handshake, which waits while out_stall is high. The line
// buffers need no clearing after reset. Any configuration write restarts the
// frame; a register value of zero counts as one, a value above the maximum as
// the maximum. in_stall holds off the next pixel until its transaction ends.
`include "mean_filter_3x3_edge_normalized_defines.svh"

module mean_filter_3x3_edge_normalized #(
  parameter int MAX_COLS   = 1024,
  parameter int MAX_ROWS   = 4096,
  parameter int PIXEL_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [mf3_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mf3_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [PIXEL_BITS-1:0]        in_pixel_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [mf3_pkg::OUT_MEAN_W-1:0] out_mean_value,
  output logic [$clog2(MAX_ROWS)-1:0]         out_row,
  output logic [$clog2(MAX_COLS)-1:0]         out_col,
  output logic                                out_last_of_run,
  output logic                                out_frame_done
);

  localparam int P  = PIXEL_BITS;
  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_PICK = 3'd2;
  localparam logic [2:0] S_CALC = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  // result slots in emission order
  localparam logic [1:0] JOB_UP_LEFT = 2'd0;
  localparam logic [1:0] JOB_UP_HERE = 2'd1;
  localparam logic [1:0] JOB_LO_LEFT = 2'd2;
  localparam logic [1:0] JOB_LO_HERE = 2'd3;

  logic [2:0]                  state_r, state_nxt;
  logic [1:0]                  jb_r, jb_nxt;
  logic [3:0]                  mask_r;
  logic [mf3_pkg::ROWS_W-1:0]  cfg_rows_r;
  logic [mf3_pkg::COLS_W-1:0]  cfg_cols_r;
  logic [RW-1:0]               row_r, rows_m1;
  logic [CW-1:0]               col_r, cols_m1;
  logic signed [P-1:0]         pix_r;
  logic [2:0][P-1:0]           cur_r, w0_r, w1_r;
  logic [2:0][P-1:0]           cur;
  logic [2*P-1:0]              rd_data;
  logic                        accept, last_col, last_row;
  logic                        col_ge1, col_ge2, row_ge1, row_ge2;
  logic                        later_jobs;

  mf3_pkg::mf3_shape_t         shape;
  logic [2:0][P-1:0]           left_col, mid_col, right_col;
  logic                        div_start, div_done;
  logic signed [P+12:0]        div_mean;

  logic signed [mf3_pkg::OUT_MEAN_W-1:0] mean_r;
  logic [RW-1:0]               orow_r;
  logic [CW-1:0]               ocol_r;
  logic                        olast_r, odone_r;

  // clamp the frame size registers
  always_comb begin
    if (cfg_rows_r == '0) begin
      rows_m1 = '0;
    end else if (32'(cfg_rows_r) > 32'(MAX_ROWS)) begin
      rows_m1 = RW'(MAX_ROWS - 1);
    end else begin
      rows_m1 = RW'(32'(cfg_rows_r) - 32'd1);
    end
    if (cfg_cols_r == '0) begin
      cols_m1 = '0;
    end else if (32'(cfg_cols_r) > 32'(MAX_COLS)) begin
      cols_m1 = CW'(MAX_COLS - 1);
    end else begin
      cols_m1 = CW'(32'(cfg_cols_r) - 32'd1);
    end
  end

  assign last_col = (col_r == cols_m1);
  assign last_row = (row_r == rows_m1);
  assign col_ge1  = (col_r != '0);
  assign col_ge2  = (col_r > CW'(1));
  assign row_ge1  = (row_r != '0);
  assign row_ge2  = (row_r > RW'(1));

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign cur      = {pix_r, rd_data[P-1:0], rd_data[2*P-1:P]};

  mf3_linebuf #(
    .DEPTH (MAX_COLS),
    .WIDTH (2 * P)
  ) u_linebuf (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_r),
    .rd_data (rd_data),
    .wr_en   (state_r == S_READ),
    .wr_addr (col_r),
    .wr_data ({rd_data[P-1:0], pix_r})
  );

  // window and row selection for the current result slot
  always_comb begin
    shape.right_en = 1'b0;
    shape.left_en  = col_ge1;
    left_col       = w1_r;
    mid_col        = cur_r;
    right_col      = cur_r;
    case (jb_r)
      JOB_UP_LEFT, JOB_LO_LEFT: begin
        shape.right_en = 1'b1;
        shape.left_en  = col_ge2;
        left_col       = w0_r;
        mid_col        = w1_r;
        right_col      = cur_r;
      end
      default: begin
      end
    endcase
    if (jb_r == JOB_UP_LEFT || jb_r == JOB_UP_HERE) begin
      shape.tlo = row_ge2 ? mf3_pkg::TLO_ALL : mf3_pkg::TLO_LOWER2;
    end else begin
      shape.tlo = row_ge1 ? mf3_pkg::TLO_LOWER2 : mf3_pkg::TLO_BOTTOM;
    end
  end

  always_comb begin
    case (jb_r)
      JOB_UP_LEFT: later_jobs = |mask_r[3:1];
      JOB_UP_HERE: later_jobs = |mask_r[3:2];
      JOB_LO_LEFT: later_jobs = mask_r[3];
      default:     later_jobs = 1'b0;
    endcase
  end

  assign div_start = (state_r == S_PICK) && mask_r[jb_r];

  mf3_mean #(
    .PIXEL_BITS (P)
  ) u_mean (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .shape     (shape),
    .left_col  (left_col),
    .mid_col   (mid_col),
    .right_col (right_col),
    .done      (div_done),
    .mean      (div_mean)
  );

  always_comb begin
    state_nxt = state_r;
    jb_nxt    = jb_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = S_PICK;
        jb_nxt    = JOB_UP_LEFT;
      end
      S_PICK: begin
        if (mask_r[jb_r]) begin
          state_nxt = S_CALC;
        end else if (jb_r == JOB_LO_HERE) begin
          state_nxt = S_FIN;
        end else begin
          jb_nxt = jb_r + 2'd1;
        end
      end
      S_CALC: begin
        if (div_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          if (jb_r == JOB_LO_HERE) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_PICK;
            jb_nxt    = jb_r + 2'd1;
          end
        end
      end
      S_FIN: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      jb_r       <= JOB_UP_LEFT;
      mask_r     <= '0;
      row_r      <= '0;
      col_r      <= '0;
      cfg_rows_r <= mf3_pkg::ROWS_W'(1);
      cfg_cols_r <= mf3_pkg::COLS_W'(1);
      w0_r       <= '0;
      w1_r       <= '0;
    end else begin
      state_r <= state_nxt;
      jb_r    <= jb_nxt;
      if (state_r == S_READ) begin
        mask_r <= {last_row && last_col, last_row && col_ge1,
                   row_ge1 && last_col, row_ge1 && col_ge1};
      end
      // advance the window and the raster position
      if (state_r == S_FIN) begin
        w0_r <= w1_r;
        w1_r <= cur_r;
      end
      if (cfg_wr_en) begin
        unique case (cfg_index)
          mf3_pkg::REG_FRAME_ROWS: cfg_rows_r <= cfg_data[mf3_pkg::ROWS_W-1:0];
          mf3_pkg::REG_FRAME_COLS: cfg_cols_r <= cfg_data[mf3_pkg::COLS_W-1:0];
          default: begin
          end
        endcase
        row_r <= '0;
        col_r <= '0;
      end else if (state_r == S_FIN) begin
        if (last_col) begin
          col_r <= '0;
          row_r <= last_row ? '0 : row_r + RW'(1);
        end else begin
          col_r <= col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) pix_r <= in_pixel_value;
    if (state_r == S_READ) cur_r <= cur;
    if (state_r == S_CALC && div_done) begin
      mean_r  <= mf3_pkg::OUT_MEAN_W'(div_mean);
      orow_r  <= (jb_r == JOB_UP_LEFT || jb_r == JOB_UP_HERE) ? row_r - RW'(1) : row_r;
      ocol_r  <= (jb_r == JOB_UP_LEFT || jb_r == JOB_LO_LEFT) ? col_r - CW'(1) : col_r;
      olast_r <= !later_jobs;
      odone_r <= (jb_r == JOB_LO_HERE);
    end
  end

  assign out_valid       = (state_r == S_OUT);
  assign out_mean_value  = mean_r;
  assign out_row         = orow_r;
  assign out_col         = ocol_r;
  assign out_last_of_run = olast_r;
  assign out_frame_done  = odone_r;

  `MF3_ASSERT_HOLDS(a_out_slot_live, out_valid, mask_r[jb_r], "result for an empty slot")
  `MF3_ASSERT_HOLDS(a_done_in_calc, div_done, state_r == S_CALC, "mean done outside calc")
  `MF3_ASSERT_HOLDS(a_frame_end_last, out_valid && out_frame_done, out_last_of_run,
                    "frame end not last of run")
  `MF3_ASSERT_HOLDS(a_pos_in_frame, state_r == S_IDLE, col_r <= cols_m1 && row_r <= rows_m1,
                    "raster position outside frame")

endmodule

>>> src/mf3_linebuf.sv
// Line buffer memory: one write port, one registered read port.
module mf3_linebuf #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/mf3_mean.sv
// Four-stage neighbourhood mean: masked sum, round, reciprocal divide, correct.
`include "mean_filter_3x3_edge_normalized_defines.svh"

module mf3_mean #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  mf3_pkg::mf3_shape_t           shape,
  input  logic [2:0][PIXEL_BITS-1:0]    left_col,
  input  logic [2:0][PIXEL_BITS-1:0]    mid_col,
  input  logic [2:0][PIXEL_BITS-1:0]    right_col,
  output logic                          done,
  output logic signed [PIXEL_BITS+12:0] mean
);

  localparam int P  = PIXEL_BITS;
  localparam int SW = P + 2;   // one column
  localparam int TW = P + 4;   // nine pixels
  localparam int XW = TW + 9;  // 2 * 256 * |sum| + count
  localparam int YW = P + 12;  // after the power-of-two part of the divisor
  localparam logic [YW-1:0] M3 = YW'((64'd1 << YW) / 64'd3);
  localparam logic [YW-1:0] M9 = YW'((64'd1 << YW) / 64'd9);

  localparam logic [1:0] K1 = 2'd0;
  localparam logic [1:0] K3 = 2'd1;
  localparam logic [1:0] K9 = 2'd2;

  function automatic logic signed [SW-1:0] col_sum(input logic [2:0][P-1:0] c,
                                                   input logic [1:0] tlo,
                                                   input logic en);
    logic signed [SW-1:0] s;
    s = '0;
    if (en) begin
      s = SW'($signed(c[2]));
      if (tlo <= mf3_pkg::TLO_LOWER2) s = s + SW'($signed(c[1]));
      if (tlo == mf3_pkg::TLO_ALL) s = s + SW'($signed(c[0]));
    end
    return s;
  endfunction

  logic [3:0] v_r;

  // stage 1
  logic signed [SW-1:0] sl_r, sm_r, sr_r;
  logic [3:0]           cnt_r;
  logic [1:0]           sh_r, ksel_r;
  logic [1:0]           nrows;
  logic [1:0]           ncols;
  logic [3:0]           cnt;
  logic [1:0]           sh, ksel;

  // stage 2
  logic signed [TW-1:0] total;
  logic [TW-1:0]        mag;
  logic [XW-1:0]        xval;
  logic [YW-1:0]        y2_r;
  logic [1:0]           ksel2_r;
  logic                 neg2_r;

  // stage 3
  logic [YW-1:0]        mconst;
  logic [2*YW-1:0]      prod;
  logic [YW-1:0]        q0_r, y3_r;
  logic [1:0]           ksel3_r;
  logic                 neg3_r;

  // stage 4
  logic [YW+3:0]        qk;
  logic [YW+3:0]        rem;
  logic [YW+3:0]        kval;
  logic                 bump;
  logic [YW-1:0]        q;
  logic signed [YW:0]   mean_r;

  always_comb begin
    nrows = 2'd3 - shape.tlo;
    ncols = 2'd1 + {1'b0, shape.left_en} + {1'b0, shape.right_en};
    cnt   = {2'b00, nrows} * {2'b00, ncols};
    case (cnt)
      4'd1:    begin sh = 2'd1; ksel = K1; end
      4'd2:    begin sh = 2'd2; ksel = K1; end
      4'd3:    begin sh = 2'd1; ksel = K3; end
      4'd4:    begin sh = 2'd3; ksel = K1; end
      4'd6:    begin sh = 2'd2; ksel = K3; end
      4'd9:    begin sh = 2'd1; ksel = K9; end
      default: begin sh = 2'd1; ksel = K1; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sl_r   <= col_sum(left_col, shape.tlo, shape.left_en);
      sm_r   <= col_sum(mid_col, shape.tlo, 1'b1);
      sr_r   <= col_sum(right_col, shape.tlo, shape.right_en);
      cnt_r  <= cnt;
      sh_r   <= sh;
      ksel_r <= ksel;
    end
  end

  always_comb begin
    total = TW'(sl_r) + TW'(sm_r) + TW'(sr_r);
    mag   = total[TW-1] ? TW'(-total) : TW'(total);
    xval  = {mag, 9'd0} + XW'(cnt_r);
  end

  always_ff @(posedge clk) begin
    if (v_r[0]) begin
      y2_r    <= YW'(xval >> sh_r);
      ksel2_r <= ksel_r;
      neg2_r  <= total[TW-1];
    end
  end

  // divide by 3 or 9 by reciprocal; the estimate is exact or one low
  always_comb begin
    mconst = (ksel2_r == K9) ? M9 : M3;
    prod   = (2*YW)'(y2_r) * (2*YW)'(mconst);
  end

  always_ff @(posedge clk) begin
    if (v_r[1]) begin
      q0_r    <= (ksel2_r == K1) ? y2_r : prod[2*YW-1:YW];
      y3_r    <= y2_r;
      ksel3_r <= ksel2_r;
      neg3_r  <= neg2_r;
    end
  end

  always_comb begin
    if (ksel3_r == K9) begin
      qk   = (YW+4)'(q0_r) + {1'b0, q0_r, 3'd0};
      kval = (YW+4)'(9);
    end else begin
      qk   = (YW+4)'(q0_r) + {3'b0, q0_r, 1'b0};
      kval = (YW+4)'(3);
    end
    rem  = (YW+4)'(y3_r) - qk;
    bump = (ksel3_r != K1) && (rem >= kval);
    q    = q0_r + YW'(bump);
  end

  always_ff @(posedge clk) begin
    if (v_r[2]) begin
      mean_r <= neg3_r ? -$signed({1'b0, q}) : $signed({1'b0, q});
    end
  end

  assign done = v_r[3];
  assign mean = mean_r;

  `MF3_ASSERT_DELAY(a_mean_latency, start, 4, done, "mean unit latency broken")
  `MF3_ASSERT_HOLDS(a_mean_single, start, v_r == 4'd0, "mean unit restarted while busy")

endmodule
